// File: hw/rtl/hrhc_pkg.sv
// Shared types and constants for the HTTP response header checker.
package hrhc_pkg;

  typedef enum logic [3:0] {
    K_HDR      = 4'd0,
    K_OK       = 4'd1,
    K_BODY     = 4'd2,
    K_IGN      = 4'd3,
    K_BAD_STAT = 4'd4,
    K_BAD_LEN  = 4'd5,
    K_BAD_TYPE = 4'd6,
    K_NO_LEN   = 4'd7,
    K_NULL     = 4'd8,
    K_LONG     = 4'd9,
    K_DROP     = 4'd10,
    K_OK_IGN   = 4'd11
  } kind_e;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_BODY   = 4'b0010,
    PH_IGNORE = 4'b0100,
    PH_DROP   = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    LK_NONE  = 2'd0,
    LK_STAT  = 2'd1,
    LK_CLEN  = 2'd2,
    LK_CTYPE = 2'd3
  } line_kind_e;

  localparam logic [1:0] CFG_MIN = 2'd0;
  localparam logic [1:0] CFG_MAX = 2'd1;

  localparam logic [23:0] MIN_RESET = 24'd1024;
  localparam logic [23:0] MAX_RESET = 24'd8388608;

  typedef struct packed {
    logic [7:0] data;
    logic       newr;
  } beat_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  body_byte;
    logic        body_last;
    logic [23:0] content_length;
  } result_t;

  function automatic logic [7:0] http_chr(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0: c = "H";
      3'd1: c = "T";
      3'd2: c = "T";
      3'd3: c = "P";
      3'd4: c = "/";
      3'd5: c = "1";
      3'd6: c = ".";
      3'd7: c = "1";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] clen_chr(input logic [3:0] p);
    logic [127:0] s;
    s = "Content-Length: ";
    return s[8 * (15 - p) +: 8];
  endfunction

  function automatic logic [7:0] ctype_chr(input logic [3:0] p);
    logic [111:0] s;
    s = "Content-Type: ";
    return (p < 4'd14) ? s[8 * (13 - p) +: 8] : 8'd0;
  endfunction

  function automatic logic [7:0] octet_chr(input logic [4:0] p);
    logic [191:0] s;
    s = "application/octet-stream";
    return (p < 5'd24) ? s[8 * (23 - p) +: 8] : 8'd0;
  endfunction

endpackage

// File: hw/rtl/http_response_header_checker.sv
// Top level of the HTTP response header checker.
// A beat passes through the input queue, the parser register and the output queue before its result is visible.
// Throughput: one beat per cycle while the receiver keeps popping; otherwise the queues fill and stall.
// Reset: all parse state cleared, queues empty, limits 1024 and 8388608.
// A queue on each side of the parser lets either end stall.
module http_response_header_checker #(
  parameter int unsigned LINE_LIMIT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        new_response_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  kind_o,
  output logic [7:0]  body_byte_o,
  output logic        body_last_o,
  output logic [23:0] content_length_o
);
  import hrhc_pkg::*;

  beat_t   in_b, q_b;
  result_t pr, out_r;
  logic    q_empty, p_rdy, p_vld, o_full;

  assign in_b = '{data: data_byte_i, newr: new_response_i};

  hrhc_fifo #(.WIDTH($bits(beat_t))) u_in (
    .clk_i, .rst_ni, .push_i(push), .data_i(in_b), .full_o(full),
    .pop_i(p_rdy), .data_o(q_b), .empty_o(q_empty)
  );

  hrhc_parser #(.LINE_LIMIT(LINE_LIMIT)) u_parse (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .valid_i(!q_empty), .beat_i(q_b), .ready_o(p_rdy),
    .valid_o(p_vld), .res_o(pr), .ready_i(!o_full)
  );

  hrhc_fifo #(.WIDTH($bits(result_t))) u_out (
    .clk_i, .rst_ni, .push_i(p_vld), .data_i(pr), .full_o(o_full),
    .pop_i(pop), .data_o(out_r), .empty_o(empty)
  );

  assign kind_o           = out_r.kind;
  assign body_byte_o      = out_r.body_byte;
  assign body_last_o      = out_r.body_last;
  assign content_length_o = out_r.content_length;
endmodule

// File: hw/rtl/hrhc_fifo.sv
// Two-entry queue, used both as the input queue in front of the parser and as the output queue.
module hrhc_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

// File: hw/rtl/hrhc_parser.sv
// Header parser and body counter: one byte in, one result out per cycle while ready_i holds.
module hrhc_parser #(
  parameter int unsigned LINE_LIMIT = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [23:0]      cfg_data_i,
  input  logic             valid_i,
  input  hrhc_pkg::beat_t  beat_i,
  output logic             ready_o,
  output logic             valid_o,
  output hrhc_pkg::result_t res_o,
  input  logic             ready_i
);
  import hrhc_pkg::*;

  logic [23:0] min_q, max_q;
  phase_e      phase_q, phase_d;
  logic [7:0]  lc_q, lc_d, pc_q, pc_d;
  line_kind_e  lk_q, lk_d;
  logic        bad_q, bad_d, neg_q, neg_d, ok_q, ok_d;
  logic [1:0]  stg_q, stg_d;
  logic [23:0] acc_q, acc_d, len_q, len_d, bc_q, bc_d;
  result_t     r;
  logic        fire;

  assign ready_o = !valid_o || ready_i;
  assign fire    = valid_i && ready_o;

  always_comb begin
    logic [7:0]  b, ch;
    logic [7:0]  p, c;
    logic [27:0] v;
    logic        digit;
    logic [1:0]  stg;
    b = beat_i.data;
    phase_d = phase_q; lc_d = lc_q; pc_d = pc_q; lk_d = lk_q;
    bad_d = bad_q; neg_d = neg_q; stg_d = stg_q; acc_d = acc_q;
    len_d = len_q; ok_d = ok_q; bc_d = bc_q;
    if (beat_i.newr) begin
      phase_d = PH_HEADER; lc_d = '0; pc_d = '0; lk_d = LK_NONE; bad_d = 1'b0;
      neg_d = 1'b0; stg_d = '0; acc_d = '0; len_d = '0; ok_d = 1'b0; bc_d = '0;
    end
    r = '0;
    r.kind = K_DROP;
    ch = pc_d;
    p = lc_d - 8'd1;
    c = p;
    v = '0; digit = 1'b0; stg = stg_d;
    case (phase_d)
      PH_HEADER: begin
        if (b == 8'h0a) begin
          if (lc_d == 8'd0 || (lc_d == 8'd1 && pc_d == 8'h0d)) begin
            lc_d = '0; pc_d = '0; lk_d = LK_NONE; bad_d = 1'b0; neg_d = 1'b0;
            stg_d = '0; acc_d = '0;
            if (len_d == '0) begin
              r.kind = K_NO_LEN;
            end else begin
              bc_d = '0;
              if (ok_d) begin
                phase_d = PH_BODY;
                r.kind = K_OK;
                r.content_length = len_d;
              end else begin
                len_d = '0;
                phase_d = PH_IGNORE;
                r.kind = K_OK_IGN;
              end
            end
          end else begin
            r.kind = K_HDR;
            if (lk_d == LK_STAT && c >= 8'd8) begin
              if (c < 8'd12 || bad_d) r.kind = K_BAD_STAT;
            end else if (lk_d == LK_CLEN && c >= 8'd16) begin
              if (bad_d || (neg_d && acc_d != '0) || acc_d < min_q || acc_d > max_q) begin
                len_d = '0;
                r.kind = K_BAD_LEN;
              end else begin
                len_d = acc_d;
              end
            end else if (lk_d == LK_CTYPE && c >= 8'd14) begin
              if (bad_d || c != 8'd38) r.kind = K_BAD_TYPE;
              else ok_d = 1'b1;
            end
            lc_d = '0; pc_d = '0; lk_d = LK_NONE; bad_d = 1'b0; neg_d = 1'b0;
            stg_d = '0; acc_d = '0;
          end
        end else if (b == 8'h00) begin
          r.kind = K_NULL;
        end else begin
          if (lc_d != 8'd0) begin
            if (p == 8'd0) begin
              lk_d = (ch == "H") ? LK_STAT : ((ch == "C") ? LK_CLEN : LK_NONE);
            end else begin
              case (lk_d)
                LK_STAT: begin
                  if (p < 8'd8) begin
                    if (ch != http_chr(p[2:0])) lk_d = LK_NONE;
                  end else if (p >= 8'd9 && p <= 8'd11) begin
                    if (ch != ((p == 8'd9) ? "2" : "0")) bad_d = 1'b1;
                  end
                end
                LK_CLEN: begin
                  if (p == 8'd8) begin
                    if (ch == "T") lk_d = LK_CTYPE;
                    else if (ch != "L") lk_d = LK_NONE;
                  end else if (p < 8'd16) begin
                    if (ch != clen_chr(p[3:0])) lk_d = LK_NONE;
                  end else if (stg != 2'd2) begin
                    digit = ch >= "0" && ch <= "9";
                    if (stg == 2'd0) begin
                      if (ch == " " || (ch >= 8'd9 && ch <= 8'd13)) begin
                        stg = 2'd3;
                      end else if (ch == "+" || ch == "-") begin
                        if (ch == "-") neg_d = 1'b1;
                        stg = 2'd1;
                      end else if (!digit) begin
                        stg = 2'd2;
                      end
                    end else if (!digit) begin
                      stg = 2'd2;
                    end
                    if (stg == 2'd3) begin
                      stg = 2'd0;
                    end else begin
                      if (stg != 2'd2 && digit) begin
                        stg = 2'd1;
                        if (!bad_d) begin
                          v = {acc_d, 3'b0} + {3'b0, acc_d, 1'b0} + {20'd0, ch - "0"};
                          if (v > 28'hffffff) bad_d = 1'b1;
                          else acc_d = v[23:0];
                        end
                      end
                      stg_d = stg;
                    end
                  end
                end
                LK_CTYPE: begin
                  if (p < 8'd14) begin
                    if (ch != ctype_chr(p[3:0])) lk_d = LK_NONE;
                  end else if (p - 8'd14 >= 8'd24) begin
                    bad_d = 1'b1;
                  end else if (ch != octet_chr(5'(p - 8'd14))) begin
                    bad_d = 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
          pc_d = b;
          lc_d = lc_d + 8'd1;
          r.kind = (lc_d >= 8'(LINE_LIMIT)) ? K_LONG : K_HDR;
        end
        if (r.kind inside {K_BAD_STAT, K_BAD_LEN, K_BAD_TYPE, K_NO_LEN, K_NULL, K_LONG})
          phase_d = PH_DROP;
      end
      PH_BODY: begin
        r.kind = K_BODY;
        r.body_byte = b;
        bc_d = bc_d + 24'd1;
        if (bc_d >= len_d) begin
          r.body_last = 1'b1;
          phase_d = PH_DROP;
        end
      end
      PH_IGNORE: r.kind = K_IGN;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_o <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_RESET; max_q <= MAX_RESET; valid_o <= 1'b0;
      phase_q <= PH_HEADER; lc_q <= '0; pc_q <= '0; lk_q <= LK_NONE;
      bad_q <= 1'b0; neg_q <= 1'b0; stg_q <= '0; acc_q <= '0; len_q <= '0;
      ok_q <= 1'b0; bc_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_MIN) min_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_MAX) max_q <= cfg_data_i;
      if (ready_o) valid_o <= valid_i;
      if (fire) begin
        phase_q <= phase_d; lc_q <= lc_d; pc_q <= pc_d; lk_q <= lk_d;
        bad_q <= bad_d; neg_q <= neg_d; stg_q <= stg_d; acc_q <= acc_d;
        len_q <= len_d; ok_q <= ok_d; bc_q <= bc_d;
      end
    end
  end
endmodule

// File: tb/sv/tb_top.sv
// Testbench for the HTTP response header checker: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

module tb_top;
  import hrhc_pkg::*;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  body_byte;
    logic        body_last;
    logic [23:0] content_length;
  } hdr_result_t;

  class header_scoreboard;
    logic [23:0] lim_min, lim_max;
    logic [3:0]  phase;
    logic [7:0]  line_cnt, pend;
    line_kind_e  lk;
    bit          bad, neg;
    logic [1:0]  stage;
    logic [23:0] accum, len_val, body_cnt;
    bit          type_ok;
    hdr_result_t pending_q[$];
    int          errors;

    function void clear_parse();
      phase = PH_HEADER; line_cnt = 0; pend = 0; lk = LK_NONE; bad = 0; neg = 0;
      stage = 0; accum = 0; len_val = 0; type_ok = 0; body_cnt = 0;
    endfunction

    function void reset_all();
      lim_min = MIN_RESET; lim_max = MAX_RESET; errors = 0;
      clear_parse();
    endfunction

    function void set_limit(logic [1:0] idx, logic [23:0] v);
      if (idx == CFG_MIN) lim_min = v; else if (idx == CFG_MAX) lim_max = v;
    endfunction

    function logic [7:0] str_chr(string s, int p);
      return s.getc(p);
    endfunction

    function void clear_line();
      line_cnt = 0; pend = 0; lk = LK_NONE; bad = 0; neg = 0; stage = 0; accum = 0;
    endfunction

    function void number_chr(logic [7:0] ch);
      bit dig;
      logic [27:0] v;
      logic [1:0] st;
      dig = ch >= "0" && ch <= "9";
      st = stage;
      if (st == 2) return;
      if (st == 0) begin
        if (ch == " " || (ch >= 9 && ch <= 13)) return;
        if (ch == "+" || ch == "-") begin
          if (ch == "-") neg = 1;
          st = 1;
        end else if (!dig) st = 2;
      end else if (!dig) st = 2;
      if (st != 2 && dig) begin
        st = 1;
        if (!bad) begin
          v = accum * 28'd10 + (ch - "0");
          if (v > 28'hFFFFFF) bad = 1; else accum = v[23:0];
        end
      end
      stage = st;
    endfunction

    function void commit_chr(logic [7:0] ch, int p);
      if (p == 0) begin
        lk = (ch == "H") ? LK_STAT : (ch == "C") ? LK_CLEN : LK_NONE;
        return;
      end
      case (lk)
        LK_STAT: begin
          if (p < 8) begin
            if (ch != str_chr("HTTP/1.1", p)) lk = LK_NONE;
          end else if (p >= 9 && p <= 11) begin
            if (ch != str_chr("200", p - 9)) bad = 1;
          end
        end
        LK_CLEN: begin
          if (p == 8) begin
            if (ch == "T") lk = LK_CTYPE;
            else if (ch != "L") lk = LK_NONE;
          end else if (p < 16) begin
            if (ch != str_chr("Content-Length: ", p)) lk = LK_NONE;
          end else number_chr(ch);
        end
        LK_CTYPE: begin
          if (p < 14) begin
            if (ch != str_chr("Content-Type: ", p)) lk = LK_NONE;
          end else if (p - 14 >= 24 || ch != str_chr("application/octet-stream", p - 14))
            bad = 1;
        end
        default: ;
      endcase
    endfunction

    function logic [3:0] judge_line(int c);
      logic [3:0] r;
      r = K_HDR;
      if (lk == LK_STAT && c >= 8) begin
        if (c < 12 || bad) r = K_BAD_STAT;
      end else if (lk == LK_CLEN && c >= 16) begin
        if (bad || (neg && accum != 0) || accum < lim_min || accum > lim_max) begin
          len_val = 0; r = K_BAD_LEN;
        end else len_val = accum;
      end else if (lk == LK_CTYPE && c >= 14) begin
        if (bad || c != 38) r = K_BAD_TYPE; else type_ok = 1;
      end
      clear_line();
      return r;
    endfunction

    function logic [3:0] header_chr(logic [7:0] b, output logic [23:0] len);
      len = 0;
      if (b == 8'h0a) begin
        if (line_cnt == 0 || (line_cnt == 1 && pend == 8'h0d)) begin
          clear_line();
          if (len_val == 0) return K_NO_LEN;
          body_cnt = 0;
          if (type_ok) begin
            phase = PH_BODY; len = len_val; return K_OK;
          end
          len_val = 0; phase = PH_IGNORE;
          return K_OK_IGN;
        end
        return judge_line(line_cnt - 1);
      end
      if (b == 0) return K_NULL;
      if (line_cnt > 0) commit_chr(pend, line_cnt - 1);
      pend = b;
      line_cnt++;
      if (line_cnt >= 128) return K_LONG;
      return K_HDR;
    endfunction

    function void note_beat(logic [7:0] b, logic nr);
      hdr_result_t r;
      logic [23:0] len;
      r = '0; r.kind = K_DROP;
      if (nr) clear_parse();
      case (phase)
        PH_HEADER: begin
          r.kind = header_chr(b, len);
          r.content_length = len;
          if (r.kind >= K_BAD_STAT && r.kind <= K_LONG) phase = PH_DROP;
        end
        PH_BODY: begin
          r.kind = K_BODY; r.body_byte = b;
          body_cnt = body_cnt + 1;
          if (body_cnt >= len_val) begin
            r.body_last = 1; phase = PH_DROP;
          end
        end
        PH_IGNORE: r.kind = K_IGN;
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(hdr_result_t got);
      hdr_result_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: kind %0d", got.kind);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, got.kind); errors++;
      end
      if (got.body_byte !== e.body_byte) begin
        $error("body_byte: expected %0d actual %0d", e.body_byte, got.body_byte); errors++;
      end
      if (got.body_last !== e.body_last) begin
        $error("body_last: expected %0d actual %0d", e.body_last, got.body_last); errors++;
      end
      if (got.content_length !== e.content_length) begin
        $error("content_length: expected %0d actual %0d", e.content_length,
               got.content_length); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = 0;
  logic [23:0] cfg_data_i = 0;
  logic        push = 0, pop = 0;
  logic        full, empty;
  logic [7:0]  data_byte_i = 0;
  logic        new_response_i = 0;
  logic [3:0]  kind_o;
  logic [7:0]  body_byte_o;
  logic        body_last_o;
  logic [23:0] content_length_o;

  http_response_header_checker dut (.*);

  header_scoreboard sb = new();
  int send_idle = 0, recv_stall = 0;
  bit hold_recv = 0;
  longint cycles = 0;
  logic [8:0] stim_q[$];

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      sb.check_result({kind_o, body_byte_o, body_last_o, content_length_o});
    pop <= !hold_recv && ($urandom_range(99) >= recv_stall);
  end

  task automatic write_cfg(logic [1:0] idx, logic [23:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    sb.set_limit(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_all();
    logic [8:0] it;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      while (send_idle != 0 && $urandom_range(99) < send_idle) begin
        push <= 0;
        @(posedge clk_i);
      end
      push <= 1; data_byte_i <= it[8:1]; new_response_i <= it[0];
      do @(posedge clk_i); while (full);
      sb.note_beat(it[8:1], it[0]);
    end
    push <= 0;
  endtask

  task automatic add_str(string s, bit first = 0);
    for (int i = 0; i < s.len(); i++)
      stim_q.push_back({s.getc(i), (first && i == 0) ? 1'b1 : 1'b0});
  endtask

  task automatic add_line(string s);
    add_str(s);
    stim_q.push_back({8'h0d, 1'b0});
    stim_q.push_back({8'h0a, 1'b0});
  endtask

  function automatic string mutate(string s);
    string t;
    int p;
    t = s;
    if ($urandom_range(3) == 0 && t.len() > 0) begin
      p = $urandom_range(t.len() - 1);
      t.putc(p, 8'($urandom_range(255)));
    end
    return t;
  endfunction

  task automatic add_response();
    int len, nb;
    string ln;
    len = $urandom_range(3) == 0 ? $urandom_range(40) : $urandom_range(12, 1);
    nb = $urandom_range(len + 3);
    add_str($urandom_range(4) == 0 ? mutate("HTTP/1.1 200 OK") : "HTTP/1.1 200 OK", 1);
    stim_q.push_back({8'h0d, 1'b0}); stim_q.push_back({8'h0a, 1'b0});
    if ($urandom_range(5) != 0) begin
      case ($urandom_range(4))
        0: ln = $sformatf("Content-Length: -%0d", len);
        1: ln = $sformatf("Content-Length:  +%0d x", len);
        2: ln = "Content-Length: 99999999";
        default: ln = $sformatf("Content-Length: %0d", len);
      endcase
      add_line(mutate(ln));
    end
    if ($urandom_range(3) == 0) add_line("X-Junk: abc");
    if ($urandom_range(4) != 0)
      add_line($urandom_range(4) == 0 ? mutate("Content-Type: application/octet-stream")
                                      : "Content-Type: application/octet-stream");
    add_str("\r\n");
    for (int i = 0; i < nb; i++) stim_q.push_back({8'($urandom_range(255)), 1'b0});
  endtask

  task automatic random_phase(int n, int si, int rs);
    send_idle = si; recv_stall = rs;
    while (n > 0) begin
      if ($urandom_range(9) == 0) begin
        stim_q.push_back({8'($urandom_range(255)), 1'($urandom_range(1))});
        n--;
      end else begin
        add_response();
        n -= stim_q.size();
      end
      send_all();
    end
    drain();
  endtask

  initial begin
    sb.reset_all();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    // directed: defaults, extremes and each special case
    add_str("HTTP/1.1 200 OK\r\nContent-Length: 2000\r\n", 1);
    add_str("Content-Type: application/octet-stream\r\n\r\nAB");
    add_str("HTTP/1.1 404\r\n", 1);
    stim_q.push_back({8'hff, 1'b1});
    stim_q.push_back({8'h00, 1'b0});
    add_str("\n", 1);
    send_all(); drain();
    write_cfg(CFG_MIN, 24'd0); write_cfg(CFG_MAX, 24'hFFFFFF);
    add_str("Content-Length: 16777215\r\n\r\nz", 1);
    add_str("Content-Length: 16777216\r\n", 1);
    add_str("HTTP\r\nC\r\nContent-Type: text\r\n", 1);
    send_all(); drain();
    for (int i = 0; i < 130; i++) stim_q.push_back({8'h61, i == 0 ? 1'b1 : 1'b0});
    send_all(); drain();
    write_cfg(CFG_MIN, 24'd1); write_cfg(CFG_MAX, 24'd20);
    random_phase(60, 0, 0);
    // hold the receiver so the block fills and backs up its input
    hold_recv = 1;
    fork
      begin repeat (60) @(posedge clk_i); hold_recv = 0; end
      random_phase(50, 65, 0);
    join
    write_cfg(CFG_MIN, 24'd5); write_cfg(CFG_MAX, 24'd8);
    random_phase(50, 0, 65);
    write_cfg(CFG_MIN, 24'd0); write_cfg(CFG_MAX, 24'd40);
    random_phase(50, 27, 27);
    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
